/* sv/hrp_pkg.sv */
package hrp_pkg;

  // Parse phase codes, as reported on parse_state.
  localparam logic [1:0] PH_LINE = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_DONE = 2'd2;
  localparam logic [1:0] PH_ERR  = 2'd3;

  // Request line sub-states.
  localparam logic [2:0] LS_START     = 3'd0;
  localparam logic [2:0] LS_METHOD    = 3'd1;
  localparam logic [2:0] LS_METHOD_SP = 3'd2;
  localparam logic [2:0] LS_URL       = 3'd3;
  localparam logic [2:0] LS_URL_SP    = 3'd4;
  localparam logic [2:0] LS_VERSION   = 3'd5;
  localparam logic [2:0] LS_ALMOST    = 3'd6;

  // Header line sub-states.
  localparam logic [2:0] HS_START    = 3'd0;
  localparam logic [2:0] HS_COLON    = 3'd1;
  localparam logic [2:0] HS_COLON_SP = 3'd2;
  localparam logic [2:0] HS_VALUE    = 3'd3;
  localparam logic [2:0] HS_ALMOST   = 3'd4;
  localparam logic [2:0] HS_BLANK    = 3'd5;

  // Byte class tags.
  localparam logic [2:0] CLS_DELIM   = 3'd0;
  localparam logic [2:0] CLS_METHOD  = 3'd1;
  localparam logic [2:0] CLS_URL     = 3'd2;
  localparam logic [2:0] CLS_VERSION = 3'd3;
  localparam logic [2:0] CLS_KEY     = 3'd4;
  localparam logic [2:0] CLS_VALUE   = 3'd5;

  localparam logic [3:0] CONN_LEN   = 4'd10;
  localparam logic [1:0] METHOD_MIN = 2'd2;

  localparam logic [7:0] CH_CR = 8'h0D;
  localparam logic [7:0] CH_LF = 8'h0A;

  typedef struct packed {
    logic [1:0] phase;
    logic [2:0] line_state;
    logic [2:0] header_state;
    logic [1:0] method_count;
    logic [3:0] version_match_pos;
    logic       old_version_seen;
    logic [3:0] key_match_pos;
    logic       key_mismatch;
    logic       persist_flag;
  } hrp_state_t;

  // Every field of the parser state resets to zero.
  localparam hrp_state_t ST_RESET = '0;

  typedef struct packed {
    logic [2:0] byte_class;
    logic       pair_done;
    logic [1:0] parse_state;
    logic       conn_persist;
  } hrp_result_t;

  function automatic logic is_alpha(input logic [7:0] c);
    return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= "0") && (c <= "9");
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == " ") || (c == 8'h09);
  endfunction

  function automatic logic [7:0] conn_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "C";
      4'd1:    ch = "o";
      4'd2:    ch = "n";
      4'd3:    ch = "n";
      4'd4:    ch = "e";
      4'd5:    ch = "c";
      4'd6:    ch = "t";
      4'd7:    ch = "i";
      4'd8:    ch = "o";
      4'd9:    ch = "n";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

  function automatic logic [7:0] http_char(input logic [3:0] idx);
    logic [7:0] ch;
    case (idx)
      4'd0:    ch = "H";
      4'd1:    ch = "T";
      4'd2:    ch = "T";
      4'd3:    ch = "P";
      4'd4:    ch = "/";
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

/* sv/http_request_head_parser_core.sv */
// Channel | Direction | Handshake              | Payload
// input   | in        | in_valid_i/in_stall_o  | data_byte_i[7:0], start_request_i
// output  | out       | out_valid_o/out_stall_i| byte_class_o[2:0], pair_done_o,
//         |           |                        | parse_state_o[1:0], conn_persist_o
//
// Throughput is one byte per clock cycle while the output is not stalled; each byte gives exactly one result.
// The byte lands in the input register, then the parse step writes the result
// register and the parser state on the same edge.
// The single parse step between the two registers sets the cycle time.
// rst_ni clears the parser state and both valid flags asynchronously.
// A stall on the output holds the result register; the input register keeps
// taking a transaction while its held byte can move on in the same cycle.
module http_request_head_parser_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [7:0] data_byte_i,
  input  logic       start_request_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [2:0] byte_class_o,
  output logic       pair_done_o,
  output logic [1:0] parse_state_o,
  output logic       conn_persist_o
);
  import hrp_pkg::*;

  // Input register: one captured transaction waiting for the parse step.
  logic        in_valid_q;
  logic [7:0]  in_byte_q;
  logic        in_start_q;

  // Parser state, updated only when a byte moves into the result register.
  hrp_state_t  st_q;
  hrp_state_t  st_d;

  // Result register.
  logic        out_valid_q;
  hrp_result_t res_q;
  hrp_result_t res_d;

  logic        adv;

  // The held byte advances whenever the result register is empty or drains
  // this cycle, so the input side only stalls when the output side is stuck.
  assign adv        = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !adv;

  hrp_step u_step (
    .st_i    (st_q),
    .start_i (in_start_q),
    .byte_i  (in_byte_q),
    .st_o    (st_d),
    .res_o   (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!in_stall_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_byte_q  <= data_byte_i;
      in_start_q <= start_request_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_RESET;
    end else if (adv) begin
      st_q <= st_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign byte_class_o   = res_q.byte_class;
  assign pair_done_o    = res_q.pair_done;
  assign parse_state_o  = res_q.parse_state;
  assign conn_persist_o = res_q.conn_persist;

`ifndef SYNTHESIS
  // A finished header line is reported only on its delimiter byte, in headers.
  a_pair_in_headers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.pair_done |->
      (res_q.parse_state == PH_HDR) && (res_q.byte_class == CLS_DELIM))
    else $error("pair_done outside header phase or on a tagged byte");

  // The persistence decision is held low while the request line is parsed.
  a_ka_in_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (res_q.parse_state == PH_LINE) |-> !res_q.conn_persist)
    else $error("conn_persist set during request line");

  // The error phase is left only by a byte that carries the start flag.
  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (st_q.phase == PH_ERR) && !(adv && in_start_q) |=> (st_q.phase == PH_ERR))
    else $error("left error phase without start");

  // The parser state moves only together with a new result.
  a_state_moves_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !adv |=> $stable(st_q))
    else $error("parser state changed without an advancing byte");
`endif

endmodule

/* sv/hrp_step.sv */
module hrp_step (
  input  hrp_pkg::hrp_state_t  st_i,
  input  logic                 start_i,
  input  logic [7:0]           byte_i,
  output hrp_pkg::hrp_state_t  st_o,
  output hrp_pkg::hrp_result_t res_o
);
  import hrp_pkg::*;

  hrp_state_t cur;
  hrp_state_t nxt;
  logic [2:0] cls;
  logic       pair;
  logic       line_err;
  logic       hdr_err;
  logic       vtrack;
  logic       ktrack;
  logic [3:0] vpos_n;
  logic       vold_n;
  logic       url_char;
  logic       key_char;

  assign url_char = (byte_i == "/") || is_alpha(byte_i) || (byte_i == ".") ||
                    is_digit(byte_i) || (byte_i == "_") || (byte_i == "-");
  assign key_char = is_alpha(byte_i) || (byte_i == "-") || (byte_i == "_") ||
                    (byte_i == "~") || (byte_i == ".");

  assign cur = start_i ? ST_RESET : st_i;

  // Substring search for the old version strings in the version text.
  always_comb begin
    vpos_n = (byte_i == "H") ? 4'd1 : 4'd0;
    vold_n = cur.old_version_seen;
    case (cur.version_match_pos)
      4'd0, 4'd1, 4'd2, 4'd3, 4'd4: begin
        if (byte_i == http_char(cur.version_match_pos)) begin
          vpos_n = cur.version_match_pos + 4'd1;
        end
      end
      4'd5: begin
        if (byte_i == "1") begin
          vpos_n = 4'd6;
        end else if (byte_i == "0") begin
          vpos_n = 4'd8;
        end
      end
      4'd6: if (byte_i == ".") vpos_n = 4'd7;
      4'd7: if (byte_i == "0") vold_n = 1'b1;
      4'd8: if (byte_i == ".") vpos_n = 4'd9;
      4'd9: if (byte_i == "9") vold_n = 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    nxt      = cur;
    cls      = CLS_DELIM;
    pair     = 1'b0;
    line_err = 1'b0;
    hdr_err  = 1'b0;
    vtrack   = 1'b0;
    ktrack   = 1'b0;
    case (cur.phase)
      PH_LINE: begin
        case (cur.line_state)
          LS_START: begin
            if (is_alpha(byte_i)) begin
              nxt.line_state   = LS_METHOD;
              nxt.method_count = 2'd1;
              cls              = CLS_METHOD;
            end else begin
              line_err = 1'b1;
            end
          end
          LS_METHOD: begin
            if (is_blank(byte_i)) begin
              if (cur.method_count < METHOD_MIN) begin
                line_err = 1'b1;
              end else begin
                nxt.line_state = LS_METHOD_SP;
              end
            end else if (is_alpha(byte_i)) begin
              if (cur.method_count < METHOD_MIN) begin
                nxt.method_count = cur.method_count + 2'd1;
              end
              cls = CLS_METHOD;
            end else begin
              line_err = 1'b1;
            end
          end
          LS_METHOD_SP: begin
            if (is_blank(byte_i)) begin
              cls = CLS_DELIM;
            end else if (byte_i == "/") begin
              nxt.line_state = LS_URL;
              cls            = CLS_URL;
            end else begin
              line_err = 1'b1;
            end
          end
          LS_URL: begin
            if (url_char) begin
              cls = CLS_URL;
            end else if (is_blank(byte_i)) begin
              nxt.line_state = LS_URL_SP;
            end else begin
              line_err = 1'b1;
            end
          end
          LS_URL_SP: begin
            if (is_blank(byte_i)) begin
              cls = CLS_DELIM;
            end else if (is_alpha(byte_i)) begin
              nxt.line_state = LS_VERSION;
              vtrack         = 1'b1;
              cls            = CLS_VERSION;
            end else begin
              line_err = 1'b1;
            end
          end
          LS_VERSION: begin
            if ((byte_i == ".") || (byte_i == "/") || is_digit(byte_i) ||
                is_alpha(byte_i)) begin
              vtrack = 1'b1;
              cls    = CLS_VERSION;
            end else if (byte_i == CH_CR) begin
              nxt.line_state = LS_ALMOST;
            end else begin
              line_err = 1'b1;
            end
          end
          LS_ALMOST: begin
            if (byte_i == CH_LF) begin
              nxt.phase = PH_HDR;
            end else begin
              line_err = 1'b1;
            end
          end
          default: line_err = 1'b1;
        endcase
      end
      PH_HDR: begin
        case (cur.header_state)
          HS_START: begin
            if (byte_i == CH_CR) begin
              nxt.header_state = HS_BLANK;
            end else if (key_char) begin
              ktrack = 1'b1;
              cls    = CLS_KEY;
            end else if (byte_i == ":") begin
              nxt.header_state = HS_COLON;
            end else begin
              hdr_err = 1'b1;
            end
          end
          HS_COLON: begin
            if (byte_i == " ") begin
              nxt.header_state = HS_COLON_SP;
            end else begin
              hdr_err = 1'b1;
            end
          end
          HS_COLON_SP: begin
            if (is_blank(byte_i)) begin
              cls = CLS_DELIM;
            end else if ((byte_i == CH_CR) || (byte_i == CH_LF)) begin
              hdr_err = 1'b1;
            end else begin
              nxt.header_state = HS_VALUE;
              cls              = CLS_VALUE;
            end
          end
          HS_VALUE: begin
            if (byte_i == CH_CR) begin
              nxt.header_state = HS_ALMOST;
            end else if (byte_i == CH_LF) begin
              hdr_err = 1'b1;
            end else begin
              cls = CLS_VALUE;
            end
          end
          HS_ALMOST: begin
            if (byte_i == CH_LF) begin
              if (!cur.key_mismatch && (cur.key_match_pos == CONN_LEN)) begin
                nxt.persist_flag = 1'b1;
              end
              nxt.key_match_pos = 4'd0;
              nxt.key_mismatch  = 1'b0;
              nxt.header_state  = HS_START;
              pair              = 1'b1;
            end else begin
              hdr_err = 1'b1;
            end
          end
          HS_BLANK: begin
            if (byte_i == CH_LF) begin
              nxt.phase = PH_DONE;
            end else begin
              hdr_err = 1'b1;
            end
          end
          default: hdr_err = 1'b1;
        endcase
      end
      default: ;
    endcase

    if (vtrack) begin
      nxt.version_match_pos = vpos_n;
      nxt.old_version_seen  = vold_n;
    end
    if (ktrack) begin
      if (!cur.key_mismatch && (cur.key_match_pos < CONN_LEN) &&
          (byte_i == conn_char(cur.key_match_pos))) begin
        nxt.key_match_pos = cur.key_match_pos + 4'd1;
      end else begin
        nxt.key_mismatch = 1'b1;
      end
    end
    // A request line error also forces the persistence decision off.
    if (line_err) begin
      nxt.old_version_seen = 1'b1;
      nxt.phase            = PH_ERR;
    end
    if (hdr_err) begin
      nxt.phase = PH_ERR;
    end
  end

  assign st_o = nxt;

  always_comb begin
    res_o.byte_class  = cls;
    res_o.pair_done   = pair;
    res_o.parse_state = nxt.phase;
    case (nxt.phase)
      PH_HDR, PH_ERR: res_o.conn_persist = !nxt.old_version_seen;
      PH_DONE:        res_o.conn_persist = nxt.persist_flag || !nxt.old_version_seen;
      default:        res_o.conn_persist = 1'b0;
    endcase
  end

endmodule

/* verif/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import hrp_pkg::*;

  // A stream of request heads is pushed through the parser one byte per
  // transaction. Every accepted byte is run through a local model of the
  // parser, and the result it predicts, or a directed row's given tag, waits in
  // a queue until the matching output transaction shows up.

  localparam int unsigned RANDOM_BYTES = 1850;
  // Cycles without any transaction on either side before the run gives up.
  // It lies far above the longest sender gap and the longest output stall.
  localparam int unsigned IDLE_LIMIT   = 2000;

  localparam logic [39:0] HTTP_PREFIX = "HTTP/";
  localparam logic [79:0] CONN_KEY    = "Connection";

  typedef struct packed {
    logic [2:0] byte_class;
    logic       pair_done;
    logic [1:0] parse_state;
    logic       conn_persist;
  } byte_tag_t;

  typedef struct packed {
    logic [7:0] data;
    logic       start;
    logic       typed;
    byte_tag_t  tag;
  } dir_row_t;

  logic       clk_i = 1'b0;
  logic       rst_ni;
  logic       in_valid_i;
  logic       in_stall_o;
  logic [7:0] data_byte_i;
  logic       start_request_i;
  logic       out_valid_o;
  logic       out_stall_i;
  logic [2:0] byte_class_o;
  logic       pair_done_o;
  logic [1:0] parse_state_o;
  logic       conn_persist_o;

  always #2 clk_i = ~clk_i;

  http_request_head_parser_core i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_byte_i    (data_byte_i),
    .start_request_i(start_request_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .byte_class_o   (byte_class_o),
    .pair_done_o    (pair_done_o),
    .parse_state_o  (parse_state_o),
    .conn_persist_o (conn_persist_o)
  );

  // Predicted results, oldest first, one per accepted input transaction.
  byte_tag_t tag_q [$];
  dir_row_t  dir_tbl [$];
  logic [7:0] req_q [$];

  // Local copy of the parser state.
  logic [1:0] ps_phase;
  logic [2:0] ps_line;
  logic [2:0] ps_hdr;
  logic [1:0] ps_methods;
  logic [3:0] ps_vpos;
  logic       ps_old;
  logic [3:0] ps_kpos;
  logic       ps_kbad;
  logic       ps_conn;

  int unsigned n_err, n_checked, n_heads, n_line_err, n_hdr_err, n_pairs, n_conn;
  int unsigned n_directed, n_random, idle_cycles;
  byte_tag_t   got, want;

  function automatic logic is_letter(input logic [7:0] c);
    return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
  endfunction

  function automatic logic is_num(input logic [7:0] c);
    return c >= "0" && c <= "9";
  endfunction

  function automatic logic is_space(input logic [7:0] c);
    return c == " " || c == 8'h09;
  endfunction

  function automatic logic [7:0] rand_letter();
    if ($urandom_range(0, 1) == 0) return 8'("A" + $urandom_range(0, 25));
    return 8'("a" + $urandom_range(0, 25));
  endfunction

  // Mostly back to back, sometimes a few cycles, rarely a long pause.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  task automatic clear_parser();
    ps_phase   = PH_LINE;
    ps_line    = LS_START;
    ps_hdr     = HS_START;
    ps_methods = '0;
    ps_vpos    = '0;
    ps_old     = 1'b0;
    ps_kpos    = '0;
    ps_kbad    = 1'b0;
    ps_conn    = 1'b0;
  endtask

  // Substring search for "HTTP/1.0" and "HTTP/0.9" inside the version text.
  // The match position restarts at one on any 'H' that does not extend it.
  task automatic track_version(input logic [7:0] c);
    logic [3:0] nxt;
    nxt = (c == "H") ? 4'd1 : 4'd0;
    if (ps_vpos < 4'd5) begin
      if (c == HTTP_PREFIX[39 - 8 * ps_vpos -: 8]) nxt = ps_vpos + 4'd1;
    end else begin
      case (ps_vpos)
        4'd5: if (c == "1") nxt = 4'd6; else if (c == "0") nxt = 4'd8;
        4'd6: if (c == ".") nxt = 4'd7;
        4'd7: if (c == "0") ps_old = 1'b1;
        4'd8: if (c == ".") nxt = 4'd9;
        4'd9: if (c == "9") ps_old = 1'b1;
        default: ;
      endcase
    end
    ps_vpos = nxt;
  endtask

  // One parse step: advances the local state and returns the result that
  // the byte should produce.
  task automatic parse_byte(input logic [7:0] c, input logic st, output byte_tag_t r);
    logic bad;
    r   = '0;
    bad = 1'b1;
    if (st) clear_parser();
    if (ps_phase == PH_LINE) begin
      case (ps_line)
        LS_START: if (is_letter(c)) begin
          ps_line      = LS_METHOD;
          ps_methods   = 2'd1;
          r.byte_class = CLS_METHOD;
          bad          = 1'b0;
        end
        LS_METHOD: begin
          if (is_space(c)) begin
            // A one-letter method is rejected at the first blank.
            if (ps_methods >= METHOD_MIN) begin
              ps_line = LS_METHOD_SP;
              bad     = 1'b0;
            end
          end else if (is_letter(c)) begin
            if (ps_methods < METHOD_MIN) ps_methods = ps_methods + 2'd1;
            r.byte_class = CLS_METHOD;
            bad          = 1'b0;
          end
        end
        LS_METHOD_SP: begin
          if (is_space(c)) begin
            bad = 1'b0;
          end else if (c == "/") begin
            ps_line      = LS_URL;
            r.byte_class = CLS_URL;
            bad          = 1'b0;
          end
        end
        LS_URL: begin
          if (c == "/" || c == "." || c == "_" || c == "-" || is_letter(c) || is_num(c)) begin
            r.byte_class = CLS_URL;
            bad          = 1'b0;
          end else if (is_space(c)) begin
            ps_line = LS_URL_SP;
            bad     = 1'b0;
          end
        end
        LS_URL_SP: begin
          if (is_space(c)) begin
            bad = 1'b0;
          end else if (is_letter(c)) begin
            ps_line = LS_VERSION;
            track_version(c);
            r.byte_class = CLS_VERSION;
            bad          = 1'b0;
          end
        end
        LS_VERSION: begin
          if (c == "." || c == "/" || is_num(c) || is_letter(c)) begin
            track_version(c);
            r.byte_class = CLS_VERSION;
            bad          = 1'b0;
          end else if (c == CH_CR) begin
            ps_line = LS_ALMOST;
            bad     = 1'b0;
          end
        end
        LS_ALMOST: if (c == CH_LF) begin
          ps_phase = PH_HDR;
          bad      = 1'b0;
        end
        default: ;
      endcase
      // An error in the request line always drops the persistence decision.
      if (bad) begin
        ps_old   = 1'b1;
        ps_phase = PH_ERR;
        n_line_err++;
      end
    end else if (ps_phase == PH_HDR) begin
      case (ps_hdr)
        HS_START: begin
          if (c == CH_CR) begin
            ps_hdr = HS_BLANK;
            bad    = 1'b0;
          end else if (is_letter(c) || c == "-" || c == "_" || c == "~" || c == ".") begin
            if (!ps_kbad && ps_kpos < CONN_LEN && c == CONN_KEY[79 - 8 * ps_kpos -: 8])
              ps_kpos = ps_kpos + 4'd1;
            else
              ps_kbad = 1'b1;
            r.byte_class = CLS_KEY;
            bad          = 1'b0;
          end else if (c == ":") begin
            ps_hdr = HS_COLON;
            bad    = 1'b0;
          end
        end
        HS_COLON: if (c == " ") begin
          ps_hdr = HS_COLON_SP;
          bad    = 1'b0;
        end
        HS_COLON_SP: begin
          if (is_space(c)) begin
            bad = 1'b0;
          end else if (c != CH_CR && c != CH_LF) begin
            ps_hdr       = HS_VALUE;
            r.byte_class = CLS_VALUE;
            bad          = 1'b0;
          end
        end
        HS_VALUE: begin
          if (c == CH_CR) begin
            ps_hdr = HS_ALMOST;
            bad    = 1'b0;
          end else if (c != CH_LF) begin
            r.byte_class = CLS_VALUE;
            bad          = 1'b0;
          end
        end
        HS_ALMOST: if (c == CH_LF) begin
          if (!ps_kbad && ps_kpos == CONN_LEN) begin
            ps_conn = 1'b1;
            n_conn++;
          end
          ps_kpos     = '0;
          ps_kbad     = 1'b0;
          ps_hdr      = HS_START;
          r.pair_done = 1'b1;
          n_pairs++;
          bad         = 1'b0;
        end
        HS_BLANK: if (c == CH_LF) begin
          ps_phase = PH_DONE;
          n_heads++;
          bad      = 1'b0;
        end
        default: ;
      endcase
      // A header error keeps the decision taken from the version.
      if (bad) begin
        ps_phase = PH_ERR;
        n_hdr_err++;
      end
    end
    r.parse_state = ps_phase;
    if (ps_phase == PH_HDR || ps_phase == PH_ERR) r.conn_persist = !ps_old;
    else if (ps_phase == PH_DONE) r.conn_persist = ps_conn || !ps_old;
  endtask

  task automatic add_row(input logic [7:0] b, input logic st, input logic typed = 1'b0,
                         input byte_tag_t tag = '0);
    dir_row_t row;
    row.data  = b;
    row.start = st;
    row.typed = typed;
    row.tag   = tag;
    dir_tbl   = {dir_tbl, row};
  endtask

  // Appends one byte to the request being built.
  task automatic put_byte(input logic [7:0] b);
    req_q = {req_q, b};
  endtask

  task automatic push_str(input string s);
    for (int i = 0; i < s.len(); i++) put_byte(s[i]);
  endtask

  task automatic push_blanks();
    repeat ($urandom_range(1, 3)) put_byte(($urandom_range(0, 1) == 0) ? " " : 8'h09);
  endtask

  // Offers one byte and holds it until the parser takes it. Valid stays high
  // across back-to-back transactions and is only lowered for a gap.
  task automatic send_byte(input logic [7:0] b, input logic st, input int unsigned gap,
                           input logic typed, input byte_tag_t tag);
    byte_tag_t r;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= b;
    start_request_i <= st;
    do @(posedge clk_i); while (in_stall_o);
    parse_byte(b, st, r);
    tag_q = {tag_q, (typed ? tag : r)};
  endtask

  // Stops offering bytes until every predicted result has come out.
  task automatic wait_drained();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (tag_q.size() != 0);
  endtask

  // Output side: compare every accepted result with the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      got = {byte_class_o, pair_done_o, parse_state_o, conn_persist_o};
      n_checked++;
      if (tag_q.size() == 0) begin
        $error("result with nothing expected: byte_class %0d, parse_state %0d",
               got.byte_class, got.parse_state);
        n_err++;
      end else begin
        want = tag_q.pop_front();
        if (got.byte_class !== want.byte_class) begin
          $error("byte_class: expected %0d, got %0d", want.byte_class, got.byte_class);
          n_err++;
        end
        if (got.pair_done !== want.pair_done) begin
          $error("pair_done: expected %0d, got %0d", want.pair_done, got.pair_done);
          n_err++;
        end
        if (got.parse_state !== want.parse_state) begin
          $error("parse_state: expected %0d, got %0d", want.parse_state, got.parse_state);
          n_err++;
        end
        if (got.conn_persist !== want.conn_persist) begin
          $error("conn_persist: expected %0d, got %0d", want.conn_persist,
                 got.conn_persist);
          n_err++;
        end
      end
    end
  end

  // Watchdog: any transaction on either side restarts the count.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  // Output stalls: random lengths, mostly short, with calm stretches where
  // the output is never held.
  initial begin
    int unsigned hold;
    hold = 0;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold != 0) begin
        hold--;
      end else if ($urandom_range(0, 99) < 3) begin
        out_stall_i <= 1'b0;
        hold = $urandom_range(30, 150);
      end else begin
        hold = pick_gap();
        out_stall_i <= (hold != 0);
        if (hold != 0) hold--;
      end
    end
  end

  initial begin
    int unsigned r, n, pos;
    logic [7:0]  b;
    logic        calm;

    in_valid_i      <= 1'b0;
    data_byte_i     <= '0;
    start_request_i <= 1'b0;
    rst_ni          <= 1'b0;
    n_err = 0; n_checked = 0; n_heads = 0; n_line_err = 0; n_hdr_err = 0;
    n_pairs = 0; n_conn = 0; n_directed = 0; n_random = 0; idle_cycles = 0;
    clear_parser();

    // Directed head: "GET /a", two blanks before an HTTP/1.0 version, one
    // header line with an empty key, the blank line, a byte after completion,
    // then a fresh start that fails on its first byte and stays in error.
    add_row("G", 1'b1, 1'b1, {CLS_METHOD, 1'b0, PH_LINE, 1'b0});
    add_row("E", 1'b0);
    add_row("T", 1'b0);
    add_row(" ", 1'b0);
    add_row("/", 1'b0);
    add_row("a", 1'b0);
    add_row(" ", 1'b0);
    add_row(8'h09, 1'b0);
    add_row("H", 1'b0);
    add_row("T", 1'b0);
    add_row("T", 1'b0);
    add_row("P", 1'b0);
    add_row("/", 1'b0);
    add_row("1", 1'b0);
    add_row(".", 1'b0);
    add_row("0", 1'b0);
    add_row(CH_CR, 1'b0);
    add_row(CH_LF, 1'b0, 1'b1, {CLS_DELIM, 1'b0, PH_HDR, 1'b0});
    add_row(":", 1'b0);
    add_row(" ", 1'b0);
    add_row("x", 1'b0);
    add_row(CH_CR, 1'b0);
    add_row(CH_LF, 1'b0, 1'b1, {CLS_DELIM, 1'b1, PH_HDR, 1'b0});
    add_row(CH_CR, 1'b0);
    add_row(CH_LF, 1'b0, 1'b1, {CLS_DELIM, 1'b0, PH_DONE, 1'b0});
    add_row(8'hFF, 1'b0, 1'b1, {CLS_DELIM, 1'b0, PH_DONE, 1'b0});
    add_row(8'h00, 1'b1, 1'b1, {CLS_DELIM, 1'b0, PH_ERR, 1'b0});
    add_row(8'h80, 1'b0, 1'b1, {CLS_DELIM, 1'b0, PH_ERR, 1'b0});

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tbl[i]) begin
      send_byte(dir_tbl[i].data, dir_tbl[i].start, pick_gap(), dir_tbl[i].typed, dir_tbl[i].tag);
      n_directed++;
    end
    // Let the output side run completely dry once before the random part.
    wait_drained();

    while (n_random < RANDOM_BYTES) begin
      req_q.delete();
      r = $urandom_range(0, 99);
      if (r < 5) begin
        // Pure noise over the whole byte range.
        repeat ($urandom_range(3, 20)) put_byte(8'($urandom_range(0, 255)));
      end else begin
        // Method: a single letter now and then, which must be rejected.
        n = ($urandom_range(0, 19) == 0) ? 1 : $urandom_range(2, 7);
        repeat (n) put_byte(rand_letter());
        push_blanks();
        put_byte("/");
        repeat ($urandom_range(0, 10)) begin
          case ($urandom_range(0, 5))
            0: put_byte("/");
            1: put_byte(rand_letter());
            2: put_byte(8'("0" + $urandom_range(0, 9)));
            3: put_byte(".");
            4: put_byte("_");
            default: put_byte("-");
          endcase
        end
        push_blanks();
        case ($urandom_range(0, 7))
          0: push_str("HTTP/1.0");
          1: push_str("HTTP/0.9");
          2: push_str("XHTTP/1.0");
          3: push_str("HHTTP/0.9");
          4: push_str("HTTP/1.01");
          5: push_str("HTTP/2");
          6: begin
            put_byte(rand_letter());
            repeat ($urandom_range(0, 6)) begin
              case ($urandom_range(0, 3))
                0: put_byte(".");
                1: put_byte("/");
                2: put_byte(8'("0" + $urandom_range(0, 9)));
                default: put_byte(rand_letter());
              endcase
            end
          end
          default: push_str("HTTP/1.1");
        endcase
        put_byte(CH_CR);
        put_byte(CH_LF);
        repeat ($urandom_range(0, 4)) begin
          // Keys near "Connection" check that only the exact key counts.
          case ($urandom_range(0, 6))
            0: push_str("Connection");
            1: push_str("Connectio");
            2: push_str("Connectionn");
            3: push_str("connection");
            4: ;
            5: push_str("Keep-Alive");
            default: begin
              repeat ($urandom_range(1, 8)) begin
                case ($urandom_range(0, 7))
                  0: put_byte("-");
                  1: put_byte("_");
                  2: put_byte("~");
                  3: put_byte(".");
                  default: put_byte(rand_letter());
                endcase
              end
            end
          endcase
          put_byte(":");
          put_byte(" ");
          if ($urandom_range(0, 4) == 0) push_blanks();
          do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF || is_space(b));
          put_byte(b);
          repeat ($urandom_range(0, 12)) begin
            do b = 8'($urandom_range(0, 255)); while (b == CH_CR || b == CH_LF);
            put_byte(b);
          end
          put_byte(CH_CR);
          put_byte(CH_LF);
        end
        put_byte(CH_CR);
        put_byte(CH_LF);

        // Break a minority of heads: a flipped byte, a cut, or a stray byte.
        r   = $urandom_range(0, 99);
        pos = $urandom_range(0, req_q.size() - 1);
        if (r < 12) begin
          req_q[pos] = 8'($urandom_range(0, 255));
        end else if (r < 18) begin
          repeat ($urandom_range(1, req_q.size() - 1)) void'(req_q.pop_back());
        end else if (r < 22) begin
          req_q.insert(pos, 8'($urandom_range(0, 255)));
        end
      end
      n_random += req_q.size();
      // A few bytes after the head are ignored once it is complete.
      if ($urandom_range(0, 99) < 15)
        repeat ($urandom_range(1, 3)) put_byte(8'($urandom_range(0, 255)));

      if ($urandom_range(0, 99) < 4) wait_drained();
      calm = ($urandom_range(0, 9) == 0);
      foreach (req_q[i]) begin
        send_byte(req_q[i],
                  (i == 0) ? ($urandom_range(0, 19) != 0) : ($urandom_range(0, 299) == 0),
                  calm ? 0 : pick_gap(), 1'b0, '0);
      end
    end

    wait_drained();
    repeat (4) @(posedge clk_i);
    $display("Ran %0d directed and %0d random bytes: %0d heads complete, %0d line errors,",
             n_directed, n_random, n_heads, n_line_err);
    $display("%0d header errors, %0d header lines (%0d Connection keys), %0d results checked.",
             n_hdr_err, n_pairs, n_conn, n_checked);
    if (n_err == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

/* files.f */
sv/hrp_pkg.sv
sv/hrp_step.sv
sv/http_request_head_parser_core.sv
verif/tb_top.sv
